@@ rtl/core/rpta_pkg.sv @@
// Package for road plane track average: payload structs, kind codes, states, constants.
// Used by every module in rtl/core.
package rpta_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam logic [2:0] KIND_ROW0   = 3'd0;
    localparam logic [2:0] KIND_ROW1   = 3'd1;
    localparam logic [2:0] KIND_ROW2   = 3'd2;
    localparam logic [2:0] KIND_TRANS  = 3'd3;
    localparam logic [2:0] KIND_NORMAL = 3'd4;
    localparam logic [2:0] KIND_SCALAR = 3'd5;
    localparam logic [2:0] KIND_COMMIT = 3'd6;

    localparam logic CFG_FACTOR = 1'b0;
    localparam logic CFG_MAXDIST = 1'b1;

    localparam logic [20:0] FACTOR_RESET  = 21'd65536;
    localparam logic [30:0] MAXDIST_RESET = 31'd655360;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic               flag_first;
        logic               flag_second;
    } item_t;

    typedef struct packed {
        logic               plane_found;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] plane_location;
        logic [4:0]         planes_used;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_PUSH, ST_RD, ST_MUL, ST_ROT, ST_OFS, ST_WB,
        ST_ARD, ST_ACC, ST_DIV, ST_DONE
    } state_t;

    // 0..2 product row, 3 offset products
    typedef struct packed {
        logic       load;
        logic       clear_ring;
        logic       push;
        logic       rd;
        logic [1:0] mul_row;
        logic       mul;
        logic       rot_sum;
        logic       ofs_sum;
        logic       wb;
        logic       acc;
        logic       div_start;
        logic       fin;
        logic       idx_clr;
        logic       idx_inc;
    } cmd_t;

    typedef struct packed {
        logic do_move;
        logic do_push;
        logic idx_last;
        logic ring_empty;
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -52'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Q16.16 product truncated toward zero
    function automatic logic signed [47:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = (p < 0) ? (p + 64'sd65535) : p;
        return q[63:16];
    endfunction

endpackage

@@ rtl/core/rpta_div.sv @@
// Restoring divider: signed dividend by small unsigned count, truncating.
// Depends on rpta_pkg.
module rpta_div
    import rpta_pkg::*;
#(
    parameter int NW = 40,
    parameter int CW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [CW-1:0]        divisor,
    output logic signed [31:0]   quotient,
    output logic                 done
);
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] mag_reg, mag_next;
    logic [CW:0]   rem_reg, rem_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          run_reg, run_next;
    logic [CW-1:0] dvs_reg, dvs_next;
    logic [CW:0]   trial;
    logic signed [NW:0] sq;

    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        run_next = run_reg;
        dvs_next = dvs_reg;
        trial    = {rem_reg[CW-1:0], mag_reg[NW-1]};
        if (start)
        begin
            neg_next = dividend[NW-1];
            mag_next = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            rem_next = '0;
            cnt_next = SW'(NW);
            run_next = 1'b1;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                mag_next = {mag_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                mag_next = {mag_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
    end

    assign sq       = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign quotient = sq[31:0];
    assign done     = !run_reg && !start;
endmodule

@@ rtl/core/rpta_ctrl.sv @@
// Commit sequencer: walks the ring for the move pass and the averaging pass.
// Depends on rpta_pkg.
module rpta_ctrl
    import rpta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    is_commit,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);
    state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start && is_commit)
                    state_next = ST_PREP;
            ST_PREP:
                if (status.do_move && !status.ring_empty)
                    state_next = ST_RD;
                else
                    state_next = ST_PUSH;
            ST_RD:
            begin
                state_next = ST_MUL;
                row_next   = 2'd0;
            end
            ST_MUL:
                if (row_reg == 2'd2)
                    state_next = ST_ROT;
                else
                    row_next = row_reg + 2'd1;
            ST_ROT:    state_next = ST_OFS;
            ST_OFS:    state_next = ST_WB;
            ST_WB:
                state_next = status.idx_last ? ST_PUSH : ST_RD;
            ST_PUSH:   state_next = ST_ARD;
            ST_ARD:
                state_next = status.ring_empty ? ST_DONE : ST_ACC;
            ST_ACC:
                state_next = status.idx_last ? ST_DIV : ST_ARD;
            ST_DIV:
                if (status.div_done)
                    state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.load = start;
            ST_PREP:
            begin
                cmd.clear_ring = !status.do_move;
                cmd.idx_clr    = 1'b1;
            end
            ST_RD:   cmd.rd = 1'b1;
            ST_MUL:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_row = row_reg;
            end
            ST_ROT:  cmd.rot_sum = 1'b1;
            ST_OFS:
            begin
                cmd.ofs_sum = 1'b1;
                cmd.mul_row = 2'd3;
            end
            ST_WB:
            begin
                cmd.wb      = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push    = status.do_push;
                cmd.idx_clr = 1'b1;
            end
            ST_ARD:  cmd.rd = 1'b1;
            ST_ACC:
            begin
                cmd.acc       = 1'b1;
                cmd.idx_inc   = 1'b1;
                cmd.div_start = status.idx_last;
            end
            ST_DIV:  cmd.fin = status.div_done;
            ST_DONE: cmd.fin = status.ring_empty;
            default: cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

@@ rtl/core/rpta_dp.sv @@
// Datapath: staged registers, plane ring memory, shared multiplier, accumulators.
// Depends on rpta_pkg and rpta_div.
module rpta_dp
    import rpta_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  cmd_t        cmd,
    input  logic [20:0] factor,
    input  logic [30:0] maxdist,
    output status_t     status,
    output result_t     result,
    output logic        result_strobe
);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int AW = 32 + FW + 1;

    logic signed [31:0] rot_reg [9];
    logic signed [31:0] tr_reg [3];
    logic signed [31:0] pl_reg [6];
    logic [2:0]         flags_reg;
    logic signed [31:0] trav_reg;

    logic signed [31:0] mem_nx [RING_DEPTH];
    logic signed [31:0] mem_ny [RING_DEPTH];
    logic signed [31:0] mem_nz [RING_DEPTH];
    logic signed [31:0] mem_of [RING_DEPTH];
    logic signed [31:0] mem_lo [RING_DEPTH];

    logic [IW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] idx_reg;

    logic signed [31:0] rx_reg, ry_reg, rz_reg, ro_reg, rl_reg;
    logic signed [47:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;

    logic signed [AW-1:0] sx_reg, sy_reg, sz_reg, so_reg;
    logic [FW-1:0]        cnt_reg;
    logic [1:0]           dsel_reg;
    logic signed [31:0]   hp_reg [5];
    logic                 strobe_reg;
    result_t              res_reg;

    logic signed [31:0] ma0, ma1, ma2, mb0, mb1, mb2;
    logic signed [51:0] sum3;
    logic signed [32:0] gap;
    logic [32:0]        agap;
    logic signed [33:0] span;
    logic signed [55:0] ahead_p;
    logic signed [55:0] ahead_q;
    logic signed [57:0] newloc;
    logic signed [AW-1:0] dvd;
    logic signed [31:0] quo;
    logic               div_done;
    logic [IW-1:0]      idx;
    logic               div_go;
    logic               div_adv;
    logic [3:0]         rbase;

    assign idx   = idx_reg[IW-1:0];
    assign rbase = 4'(item.kind[1:0]) * 4'd3;

    always_comb
    begin
        ma0 = rot_reg[0]; ma1 = rot_reg[1]; ma2 = rot_reg[2];
        mb0 = rx_reg; mb1 = ry_reg; mb2 = rz_reg;
        unique case (cmd.mul_row)
            2'd0:
            begin
                ma0 = rot_reg[0]; ma1 = rot_reg[1]; ma2 = rot_reg[2];
            end
            2'd1:
            begin
                ma0 = rot_reg[3]; ma1 = rot_reg[4]; ma2 = rot_reg[5];
            end
            2'd2:
            begin
                ma0 = rot_reg[6]; ma1 = rot_reg[7]; ma2 = rot_reg[8];
            end
            default:
            begin
                ma0 = tr_reg[0]; ma1 = tr_reg[1]; ma2 = tr_reg[2];
                mb0 = nx_reg; mb1 = ny_reg; mb2 = nz_reg;
            end
        endcase
    end

    assign sum3 = 52'(p0_reg) + 52'(p1_reg) + 52'(p2_reg);

    assign span    = 34'(pl_reg[5]) - 34'(pl_reg[4]);
    assign ahead_p = 56'($signed({1'b0, factor})) * 56'(span);
    assign ahead_q = (ahead_p < 0) ? ((ahead_p + 56'sd131071) >>> 17) : (ahead_p >>> 17);
    assign newloc  = 58'(trav_reg) + 58'(pl_reg[4]) + 58'(ahead_q);

    assign gap  = 33'(rl_reg) - 33'(trav_reg);
    assign agap = gap[32] ? 33'(-gap) : 33'(gap);

    always_comb
    begin
        unique case (dsel_reg)
            2'd0:    dvd = sx_reg;
            2'd1:    dvd = sy_reg;
            2'd2:    dvd = sz_reg;
            default: dvd = so_reg;
        endcase
    end

    rpta_div #(.NW(AW), .CW(FW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (dvd),
        .divisor  (cnt_reg),
        .quotient (quo),
        .done     (div_done)
    );

    logic div_pend_reg, div_pend_next;
    assign div_go = div_pend_reg;

    assign div_adv = div_done && !cmd.div_start && !div_pend_reg
                     && dsel_reg != 2'd3 && !cmd.fin;

    always_comb
    begin
        div_pend_next = div_pend_reg;
        if (cmd.div_start || div_adv)
            div_pend_next = 1'b1;
        else if (div_pend_reg)
            div_pend_next = 1'b0;
    end

    logic acc_hit;
    assign acc_hit = cmd.acc && (agap < {2'b0, maxdist});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                tr_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
                pl_reg[i] <= '0;
            for (int i = 0; i < 5; i++)
                hp_reg[i] <= '0;
            flags_reg    <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            strobe_reg   <= 1'b0;
            div_pend_reg <= 1'b0;
            dsel_reg     <= 2'd3;
            cnt_reg      <= '0;
        end
        else
        begin
            strobe_reg   <= cmd.fin;
            div_pend_reg <= div_pend_next;
            if (cmd.load)
            begin
                unique case (item.kind)
                    KIND_ROW0, KIND_ROW1, KIND_ROW2:
                    begin
                        rot_reg[rbase]        <= item.value_a;
                        rot_reg[rbase + 4'd1] <= item.value_b;
                        rot_reg[rbase + 4'd2] <= item.value_c;
                    end
                    KIND_TRANS:
                    begin
                        tr_reg[0]    <= item.value_a;
                        tr_reg[1]    <= item.value_b;
                        tr_reg[2]    <= item.value_c;
                        flags_reg[0] <= item.flag_first;
                    end
                    KIND_NORMAL:
                    begin
                        pl_reg[0] <= item.value_a;
                        pl_reg[1] <= item.value_b;
                        pl_reg[2] <= item.value_c;
                    end
                    KIND_SCALAR:
                    begin
                        pl_reg[3]      <= item.value_a;
                        pl_reg[4]      <= item.value_b;
                        pl_reg[5]      <= item.value_c;
                        flags_reg[2:1] <= {item.flag_second, item.flag_first};
                    end
                    default:
                    begin
                        cnt_reg <= '0;
                    end
                endcase
            end
            if (cmd.clear_ring)
            begin
                fill_reg <= '0;
                head_reg <= '0;
            end
            if (cmd.push)
            begin
                head_reg <= (32'(head_reg) == RING_DEPTH - 1) ? '0 : head_reg + 1'b1;
                if (32'(fill_reg) < RING_DEPTH)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (acc_hit)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.div_start)
                dsel_reg <= 2'd0;
            else if (div_go)
                dsel_reg <= dsel_reg;
            if (div_adv)
            begin
                if (cnt_reg != '0)
                    hp_reg[{1'b0, dsel_reg}] <= quo;
                dsel_reg <= dsel_reg + 2'd1;
            end
            if (cmd.fin && cnt_reg != '0)
            begin
                hp_reg[3] <= quo;
                hp_reg[4] <= trav_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && item.kind == KIND_COMMIT)
        begin
            trav_reg <= item.value_a;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sz_reg   <= '0;
            so_reg   <= '0;
        end
        if (cmd.rd)
        begin
            rx_reg <= mem_nx[idx];
            ry_reg <= mem_ny[idx];
            rz_reg <= mem_nz[idx];
            ro_reg <= mem_of[idx];
            rl_reg <= mem_lo[idx];
        end
        if (cmd.mul || cmd.ofs_sum)
        begin
            p0_reg <= qscale(64'(ma0) * 64'(mb0));
            p1_reg <= qscale(64'(ma1) * 64'(mb1));
            p2_reg <= qscale(64'(ma2) * 64'(mb2));
        end
        if (cmd.mul && cmd.mul_row == 2'd1)
            nx_reg <= sat32(sum3);
        if (cmd.mul && cmd.mul_row == 2'd2)
            ny_reg <= sat32(sum3);
        if (cmd.rot_sum)
            nz_reg <= sat32(sum3);
        if (cmd.wb)
        begin
            mem_nx[idx] <= nx_reg;
            mem_ny[idx] <= ny_reg;
            mem_nz[idx] <= nz_reg;
            mem_of[idx] <= sat32(52'(ro_reg) + sum3);
        end
        if (cmd.push)
        begin
            mem_nx[head_reg] <= pl_reg[0];
            mem_ny[head_reg] <= pl_reg[1];
            mem_nz[head_reg] <= pl_reg[2];
            mem_of[head_reg] <= sat32(-52'(pl_reg[3]));
            mem_lo[head_reg] <= (newloc > 58'sd2147483647) ? 32'sh7fffffff :
                                (newloc < -58'sd2147483648) ? 32'sh80000000 : newloc[31:0];
        end
        if (cmd.acc && acc_hit)
        begin
            sx_reg <= sx_reg + AW'(rx_reg);
            sy_reg <= sy_reg + AW'(ry_reg);
            sz_reg <= sz_reg + AW'(rz_reg);
            so_reg <= so_reg + AW'(ro_reg);
        end
        if (cmd.fin)
        begin
            res_reg.plane_found    <= (cnt_reg != '0);
            res_reg.normal_x       <= hp_reg[0];
            res_reg.normal_y       <= hp_reg[1];
            res_reg.normal_z       <= hp_reg[2];
            res_reg.plane_offset   <= (cnt_reg != '0) ? quo : hp_reg[3];
            res_reg.plane_location <= (cnt_reg != '0) ? trav_reg : hp_reg[4];
            res_reg.planes_used    <= 5'(cnt_reg);
        end
    end

    assign status.do_move    = flags_reg[0];
    assign status.do_push    = flags_reg[2] && flags_reg[1];
    assign status.idx_last   = (idx_reg + 1'b1 >= fill_reg);
    assign status.ring_empty = (fill_reg == '0);
    assign status.div_done   = div_done && !div_go && !cmd.div_start && (dsel_reg == 2'd3);

    assign result        = res_reg;
    assign result_strobe = strobe_reg;
endmodule

@@ rtl/core/road_plane_track_average_top.sv @@
// Road plane track average top level: command port, config port, controller, datapath.
// Depends on rpta_pkg, rpta_ctrl, rpta_dp.
//
// Usage: present an item on item with start high; it is taken at an edge where busy is low.
// Staging items (rotation rows, translation, normal, scalars) are taken without leaving idle and give no result.
// A commit walks the ring: a move pass over every stored plane when ego
// motion is valid (three row products and an offset product through one 3-lane
// multiplier), then an averaging pass over the planes, then four serial divides
// of the sums by the count.
// When the ring holds planes, the result is on result in the last busy cycle;
// with an empty ring it comes after busy has dropped.
// The commit result is on result for one cycle with result_valid high; the
// receiver cannot stall, so it must take it then.
// Configuration writes on cfg_valid/cfg_ready are always ready; write them only
// while idle. Reset clears the ring, staged values and held plane, and sets the config registers to their defaults.
module road_plane_track_average_top
    import rpta_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output result_t     result,
    output logic        result_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    cmd_t        cmd;
    status_t     status;
    logic [20:0] factor_reg;
    logic [30:0] maxdist_reg;
    logic        busy_int;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg  <= FACTOR_RESET;
            maxdist_reg <= MAXDIST_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FACTOR:  factor_reg  <= cfg_data[20:0];
                CFG_MAXDIST: maxdist_reg <= cfg_data[30:0];
                default:     factor_reg  <= factor_reg;
            endcase
        end
    end

    rpta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy_int),
        .is_commit (item.kind == KIND_COMMIT),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy_int)
    );

    rpta_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .factor        (factor_reg),
        .maxdist       (maxdist_reg),
        .status        (status),
        .result        (result),
        .result_strobe (result_valid)
    );

    assign busy = busy_int;
endmodule
